// File: src/ffs_pkg.sv
// Package for the flash free space scanner: item, result and configuration types,
// opcodes, phase codes, register indexes and reset values.
// No dependencies.
package ffs_pkg;

  localparam int ADDR_W = 25;
  localparam int SUM_W = ADDR_W + 1;
  localparam int OUT_ADDR_W = 24;
  localparam int PPS_W = 9;
  localparam int RUN_W = 3;

  localparam int PAGE_BYTES_DEFAULT = 256;
  localparam int RUN_NEEDED_DEFAULT = 4;

  localparam logic [ADDR_W-1:0] TOTAL_BYTES_RESET = 25'd16777216;
  localparam logic [PPS_W-1:0] PPS_RESET = 9'd256;
  localparam logic [ADDR_W-1:0] FULL_LIMIT_RESET = 25'd15938355;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;
  localparam logic [RUN_W-1:0] RUN_MAX = 3'd7;

  localparam logic [1:0] CFG_TOTAL_BYTES = 2'd0;
  localparam logic [1:0] CFG_PAGES_PER_SECTOR = 2'd1;
  localparam logic [1:0] CFG_FULL_LIMIT = 2'd2;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;
  localparam logic OUTCOME_ENABLED = 1'b0;
  localparam logic OUTCOME_FULL = 1'b1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_FAIL  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SECTOR = 2'd1,
    PH_PAGE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       page_end;
  } item_t;

  typedef struct packed {
    logic                  kind;
    logic [OUT_ADDR_W-1:0] address;
    logic                  outcome;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] total_bytes;
    logic [ADDR_W-1:0] full_limit;
  } cfg_t;

endpackage

// File: src/flash_free_space_scanner_unit.sv
// Flash free space scanner: finds the address where a log may resume in a serial flash.
// An accepted item is captured in the input register, and its result is registered in the output register.
// Throughput is one item per cycle; the input register, decision logic and result
// register form a single pass, and a held result stalls input only when it is not taken.
// Synchronous reset returns the scan to idle and the configuration to its defaults.
module flash_free_space_scanner_unit #(
  parameter int PAGE_BYTES = ffs_pkg::PAGE_BYTES_DEFAULT,
  parameter int RUN_NEEDED = ffs_pkg::RUN_NEEDED_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    opcode,
  input  logic [7:0]                    data_byte,
  input  logic                          page_end,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          kind,
  output logic [ffs_pkg::OUT_ADDR_W-1:0] address,
  output logic                          outcome,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [ffs_pkg::ADDR_W-1:0]    cfg_data
);
  import ffs_pkg::*;

  localparam int SB_W = PPS_W + $clog2(PAGE_BYTES + 1);

  item_t           item_in;
  item_t           held;
  logic            held_valid;
  logic            can_take;
  logic            advance;
  cfg_t            cfg;
  logic [SB_W-1:0] sector_bytes;
  logic            res_valid;
  result_t         res;
  result_t         result;

  assign item_in.opcode = opcode;
  assign item_in.data_byte = data_byte;
  assign item_in.page_end = page_end;
  assign advance = held_valid && can_take;
  assign kind = result.kind;
  assign address = result.address;
  assign outcome = result.outcome;

  ffs_cfg_regs #(
    .PAGE_BYTES(PAGE_BYTES),
    .SB_W(SB_W)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg),
    .sector_bytes(sector_bytes)
  );

  ffs_in_stage u_in (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item_in(item_in),
    .held_valid(held_valid),
    .held(held),
    .advance(advance)
  );

  ffs_scan_core #(
    .PAGE_BYTES(PAGE_BYTES),
    .RUN_NEEDED(RUN_NEEDED),
    .SB_W(SB_W)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .item(held),
    .cfg(cfg),
    .sector_bytes(sector_bytes),
    .res_valid(res_valid),
    .res(res)
  );

  ffs_out_stage u_out (
    .clk(clk),
    .rst(rst),
    .res_valid(advance && res_valid),
    .res(res),
    .can_take(can_take),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

endmodule

// File: src/ffs_cfg_regs.sv
// Configuration registers of the flash free space scanner.
// Holds device size and full limit, and the sector size in bytes worked out at write time.
// Depends on ffs_pkg.
module ffs_cfg_regs #(
  parameter int PAGE_BYTES = ffs_pkg::PAGE_BYTES_DEFAULT,
  parameter int SB_W = ffs_pkg::PPS_W + $clog2(PAGE_BYTES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [ffs_pkg::ADDR_W-1:0] cfg_data,
  output ffs_pkg::cfg_t        cfg,
  output logic [SB_W-1:0]      sector_bytes
);
  import ffs_pkg::*;

  logic [PPS_W-1:0] pps_eff;
  logic [SB_W-1:0]  sector_bytes_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    pps_eff = (cfg_data[PPS_W-1:0] == '0) ? PPS_W'(1) : cfg_data[PPS_W-1:0];
    sector_bytes_next = SB_W'(pps_eff) * SB_W'(PAGE_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_bytes <= TOTAL_BYTES_RESET;
      cfg.full_limit <= FULL_LIMIT_RESET;
      sector_bytes <= SB_W'(PPS_RESET) * SB_W'(PAGE_BYTES);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOTAL_BYTES: cfg.total_bytes <= cfg_data;
        CFG_PAGES_PER_SECTOR: sector_bytes <= sector_bytes_next;
        CFG_FULL_LIMIT: cfg.full_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/ffs_in_stage.sv
// Input register of the flash free space scanner.
// Captures one item per cycle while not stalled, and holds it until the scan core takes it.
// Depends on ffs_pkg.
module ffs_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  ffs_pkg::item_t item_in,
  output logic           held_valid,
  output ffs_pkg::item_t held,
  input  logic           advance
);
  import ffs_pkg::*;

  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      held <= item_in;
    end
  end

endmodule

// File: src/ffs_scan_core.sv
// Scan state and per-item decision logic of the flash free space scanner.
// Updates phase, addresses and page flags, and forms at most one result per item.
// Depends on ffs_pkg.
module ffs_scan_core #(
  parameter int PAGE_BYTES = ffs_pkg::PAGE_BYTES_DEFAULT,
  parameter int RUN_NEEDED = ffs_pkg::RUN_NEEDED_DEFAULT,
  parameter int SB_W = ffs_pkg::PPS_W + $clog2(PAGE_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  ffs_pkg::item_t   item,
  input  ffs_pkg::cfg_t    cfg,
  input  logic [SB_W-1:0]  sector_bytes,
  output logic             res_valid,
  output ffs_pkg::result_t res
);
  import ffs_pkg::*;

  localparam logic [SUM_W-1:0] BACK = SUM_W'(PAGE_BYTES * (RUN_NEEDED - 1));
  localparam logic [RUN_W-1:0] RUN_GOAL = RUN_W'(RUN_NEEDED);

  phase_t            phase, phase_next;
  logic [ADDR_W-1:0] current_address, current_address_next;
  logic [ADDR_W-1:0] window_start, window_start_next;
  logic              page_all_erased, page_all_erased_next;
  logic [RUN_W-1:0]  empty_run, empty_run_next;

  logic              page_empty;
  logic [SUM_W-1:0]  cur_w;
  logic [SUM_W-1:0]  sb_w;
  logic [SUM_W-1:0]  next_sector;
  logic [SUM_W-1:0]  next_page;
  logic [SUM_W-1:0]  window_end;
  logic [ADDR_W-1:0] rewind;
  logic [SUM_W-1:0]  back_addr;
  logic [RUN_W-1:0]  run_step;

  function automatic logic [ADDR_W-1:0] sat25(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? {ADDR_W{1'b1}} : v[ADDR_W-1:0];
  endfunction

  function automatic logic [OUT_ADDR_W-1:0] sat24(input logic [SUM_W-1:0] v);
    return (|v[SUM_W-1:OUT_ADDR_W]) ? {OUT_ADDR_W{1'b1}} : v[OUT_ADDR_W-1:0];
  endfunction

  always_comb begin
    page_empty = page_all_erased && (item.data_byte == ERASED_BYTE);
    cur_w = SUM_W'(current_address);
    sb_w = SUM_W'(sector_bytes);
    next_sector = cur_w + sb_w;
    next_page = cur_w + SUM_W'(PAGE_BYTES);
    window_end = SUM_W'(window_start) + (sb_w << 1);
    rewind = (cur_w >= sb_w) ? ADDR_W'(cur_w - sb_w) : '0;
    back_addr = (cur_w >= BACK) ? (cur_w - BACK) : '0;
    if (!page_empty) begin
      run_step = '0;
    end else if (empty_run == RUN_MAX) begin
      run_step = RUN_MAX;
    end else begin
      run_step = empty_run + RUN_W'(1);
    end
  end

  always_comb begin
    phase_next = phase;
    current_address_next = current_address;
    window_start_next = window_start;
    page_all_erased_next = page_all_erased;
    empty_run_next = empty_run;
    case (opcode_t'(item.opcode))
      OP_START: begin
        current_address_next = '0;
        window_start_next = '0;
        page_all_erased_next = 1'b1;
        empty_run_next = '0;
        phase_next = (cfg.total_bytes == '0) ? PH_IDLE : PH_SECTOR;
      end
      OP_FAIL: begin
        phase_next = PH_IDLE;
      end
      OP_DATA: begin
        if (phase != PH_IDLE) begin
          page_all_erased_next = item.page_end ? 1'b1 : page_empty;
          if (item.page_end) begin
            if (phase == PH_SECTOR) begin
              if (page_empty && current_address == '0) begin
                phase_next = PH_IDLE;
              end else if (page_empty) begin
                window_start_next = rewind;
                current_address_next = rewind;
                empty_run_next = '0;
                phase_next = PH_PAGE;
              end else begin
                current_address_next = sat25(next_sector);
                if (next_sector >= SUM_W'(cfg.total_bytes)) begin
                  phase_next = PH_IDLE;
                end
              end
            end else begin
              empty_run_next = run_step;
              if (current_address >= cfg.full_limit || run_step == RUN_GOAL) begin
                phase_next = PH_IDLE;
              end else begin
                current_address_next = sat25(next_page);
                if (next_page >= window_end) begin
                  phase_next = PH_IDLE;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res.kind = KIND_READ;
    res.address = '0;
    res.outcome = OUTCOME_ENABLED;
    case (opcode_t'(item.opcode))
      OP_START: begin
        res_valid = 1'b1;
        if (cfg.total_bytes == '0) begin
          res.kind = KIND_DONE;
          res.outcome = OUTCOME_FULL;
        end
      end
      OP_FAIL: begin
        if (phase != PH_IDLE) begin
          res_valid = 1'b1;
          res.kind = KIND_DONE;
          res.address = sat24(cur_w);
          res.outcome = OUTCOME_FULL;
        end
      end
      OP_DATA: begin
        if (phase != PH_IDLE && item.page_end) begin
          res_valid = 1'b1;
          if (phase == PH_SECTOR) begin
            if (page_empty && current_address == '0) begin
              res.kind = KIND_DONE;
            end else if (page_empty) begin
              res.address = sat24(SUM_W'(rewind));
            end else if (next_sector >= SUM_W'(cfg.total_bytes)) begin
              res.kind = KIND_DONE;
              res.address = sat24(next_sector);
              res.outcome = OUTCOME_FULL;
            end else begin
              res.address = sat24(SUM_W'(sat25(next_sector)));
            end
          end else begin
            if (current_address >= cfg.full_limit) begin
              res.kind = KIND_DONE;
              res.address = sat24(cur_w);
              res.outcome = OUTCOME_FULL;
            end else if (run_step == RUN_GOAL) begin
              res.kind = KIND_DONE;
              res.address = sat24(back_addr);
            end else if (next_page >= window_end) begin
              res.kind = KIND_DONE;
              res.address = sat24(next_page);
              res.outcome = OUTCOME_FULL;
            end else begin
              res.address = sat24(SUM_W'(sat25(next_page)));
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      current_address <= '0;
      window_start <= '0;
      page_all_erased <= 1'b1;
      empty_run <= '0;
    end else if (advance) begin
      phase <= phase_next;
      current_address <= current_address_next;
      window_start <= window_start_next;
      page_all_erased <= page_all_erased_next;
      empty_run <= empty_run_next;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && res.kind == KIND_DONE) |=> (phase == PH_IDLE))
    else $error("scan finished but phase did not return to idle");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && item.opcode == OP_START) |=>
      (current_address == '0 && window_start == '0 && empty_run == '0 && page_all_erased))
    else $error("start item did not clear the scan state");

  a_page_end_rearms: assert property (@(posedge clk) disable iff (rst)
    (advance && phase != PH_IDLE && item.opcode == OP_DATA && item.page_end) |=>
      page_all_erased)
    else $error("erased flag not rearmed after a page end");

  a_idle_data_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE && item.opcode != OP_START) |-> !res_valid)
    else $error("result formed while idle");

endmodule

// File: src/ffs_out_stage.sv
// Result register of the flash free space scanner.
// Holds one result until the receiver takes it; a free or draining register lets the core advance.
// Depends on ffs_pkg.
module ffs_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  ffs_pkg::result_t res,
  output logic             can_take,
  output logic             result_valid,
  input  logic             result_stall,
  output ffs_pkg::result_t result
);
  import ffs_pkg::*;

  assign can_take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_take) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      result <= res;
    end
  end

endmodule
